@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define PESEV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Check on every clock edge, reset included.
`define PESEV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

@@ hdl/pesev_pkg.sv @@
`timescale 1ns / 1ps

package pesev_pkg;

  // Sizes
  localparam int StackDepth = 32;
  localparam int AddrW      = $clog2(StackDepth);
  localparam int SpW        = $clog2(StackDepth + 1);
  localparam int DataW      = 32;
  localparam int FracW      = 16;
  localparam int OpW        = 3;
  localparam int ErrW       = 3;

  // Token kinds
  localparam logic [OpW-1:0] OpPush = 3'd0;
  localparam logic [OpW-1:0] OpAdd  = 3'd1;
  localparam logic [OpW-1:0] OpSub  = 3'd2;
  localparam logic [OpW-1:0] OpMul  = 3'd3;
  localparam logic [OpW-1:0] OpDiv  = 3'd4;

  // Error codes
  localparam logic [ErrW-1:0] ErrNone  = 3'd0;
  localparam logic [ErrW-1:0] ErrDiv0  = 3'd1;
  localparam logic [ErrW-1:0] ErrUnder = 3'd2;
  localparam logic [ErrW-1:0] ErrOver  = 3'd3;
  localparam logic [ErrW-1:0] ErrSat   = 3'd4;

  // Saturation limits of Q16.16
  localparam logic [DataW-1:0] QMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] QMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [3:0] {
    StIdle,
    StDispatch,
    StPopA,
    StPopB,
    StCapB,
    StExec,
    StMulFin,
    StDivRun,
    StPushRes,
    StTopRd,
    StTopWait
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_tok;
    logic push_opd;
    logic pop_a;
    logic pop_b;
    logic cap_a;
    logic cap_b;
    logic exec;
    logic mul_fin;
    logic div_fin;
    logic push_res;
    logic top_rd;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           last;
    logic           div_done;
    logic           out_free;
  } status_t;

endpackage

@@ hdl/pesev_ram.sv @@
`timescale 1ns / 1ps

module pesev_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/pesev_div.sv @@
`timescale 1ns / 1ps

// Restoring divider: quotient of (dividend << FracW) / divisor, one bit per cycle.
// Valid only when the quotient fits in DataW bits.
module pesev_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pesev_pkg::DataW-1:0]  dividend_i,
  input  logic [pesev_pkg::DataW-1:0]  divisor_i,
  output logic [pesev_pkg::DataW-1:0]  quotient_o,
  output logic                         done_o
);

  localparam int CntW = $clog2(pesev_pkg::DataW + 1);
  localparam int HiW  = pesev_pkg::DataW - pesev_pkg::FracW;

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [pesev_pkg::DataW-1:0] rem_q, rem_d;
  logic [pesev_pkg::DataW-1:0] dvd_q, dvd_d;
  logic [pesev_pkg::DataW-1:0] quo_q, quo_d;
  logic [pesev_pkg::DataW-1:0] dsr_q, dsr_d;
  logic [pesev_pkg::DataW:0]   trial;
  logic [pesev_pkg::DataW:0]   diff;
  logic                        ge;

  // One quotient bit per step
  assign trial = {rem_q, dvd_q[pesev_pkg::DataW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(pesev_pkg::DataW);
      rem_d  = {{pesev_pkg::FracW{1'b0}}, dividend_i[pesev_pkg::DataW-1:pesev_pkg::FracW]};
      dvd_d  = {dividend_i[HiW-1:0], {pesev_pkg::FracW{1'b0}}};
      quo_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[pesev_pkg::DataW-1:0] : trial[pesev_pkg::DataW-1:0];
      dvd_d = {dvd_q[pesev_pkg::DataW-2:0], 1'b0};
      quo_d = {quo_q[pesev_pkg::DataW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

@@ hdl/pesev_dp.sv @@
`timescale 1ns / 1ps

module pesev_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pesev_pkg::cmd_t              cmd_i,
  output pesev_pkg::status_t           status_o,
  input  logic [pesev_pkg::OpW-1:0]    op_i,
  input  logic signed [pesev_pkg::DataW-1:0] operand_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [pesev_pkg::DataW-1:0] result_o,
  output logic [pesev_pkg::ErrW-1:0]   error_o
);

  localparam int DW = pesev_pkg::DataW;
  localparam int FW = pesev_pkg::FracW;

  // Token register
  logic [pesev_pkg::OpW-1:0] tok_op_q;
  logic                      tok_last_q;
  logic [DW-1:0]             tok_opd_q;

  // Stack control
  logic [pesev_pkg::SpW-1:0]  sp_q, sp_d, sp_m1;
  logic                       sp_empty, sp_full;
  logic                       rd_hit_q, rd_hit_d;
  logic                       we, re;
  logic [DW-1:0]              wdata, rdata;
  logic [pesev_pkg::ErrW-1:0] err_q, err_d;
  logic                       raise;
  logic [pesev_pkg::ErrW-1:0] raise_code;

  // Operands and arithmetic
  logic signed [DW-1:0]   a_q, b_q;
  logic [DW-1:0]          res_q, res_d;
  logic signed [2*DW-1:0] prod_q, prod_d;
  logic [DW:0]            sum;
  logic                   sum_ovf;
  logic                   mul_fits;
  logic [DW-1:0]          a_mag, b_mag;
  logic                   div_pre_ovf;
  logic                   dz_q, ovf_q, neg_q, asign_q;
  logic                   div_start, div_done;
  logic [DW-1:0]          quo;
  logic                   quo_big;

  // Output register
  logic                   out_valid_q;
  logic [DW-1:0]          out_res_q;
  logic [pesev_pkg::ErrW-1:0] out_err_q;
  logic                   out_free;

  assign sp_m1    = sp_q - 1'b1;
  assign sp_empty = (sp_q == '0);
  assign sp_full  = (sp_q == pesev_pkg::SpW'(pesev_pkg::StackDepth));
  assign out_free = !out_valid_q || out_ready_i;

  // Add or subtract with one extra bit
  always_comb begin
    if (tok_op_q == pesev_pkg::OpSub) begin
      sum = {a_q[DW-1], a_q} - {b_q[DW-1], b_q};
    end else begin
      sum = {a_q[DW-1], a_q} + {b_q[DW-1], b_q};
    end
  end
  assign sum_ovf = sum[DW] ^ sum[DW-1];

  // Product fits when bits above the kept window match its sign
  assign mul_fits = (prod_q[2*DW-1:DW+FW-1] == {(DW-FW+1){prod_q[2*DW-1]}});

  // Magnitudes for the divider
  assign a_mag       = a_q[DW-1] ? (~a_q + 1'b1) : a_q;
  assign b_mag       = b_q[DW-1] ? (~b_q + 1'b1) : b_q;
  assign div_pre_ovf = ({{FW{1'b0}}, a_mag} >= {b_mag, {FW{1'b0}}});
  assign div_start   = cmd_i.exec && (tok_op_q == pesev_pkg::OpDiv);
  assign quo_big     = neg_q ? (quo > pesev_pkg::QMin) : quo[DW-1];

  pesev_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_mag),
    .divisor_i  (b_mag),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  pesev_ram #(
    .Width (DW),
    .Depth (pesev_pkg::StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (sp_q[pesev_pkg::AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (sp_m1[pesev_pkg::AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Stack pointer, memory port and error raising
  always_comb begin
    sp_d       = sp_q;
    rd_hit_d   = rd_hit_q;
    we         = 1'b0;
    re         = 1'b0;
    wdata      = cmd_i.push_opd ? tok_opd_q : res_q;
    raise      = 1'b0;
    raise_code = pesev_pkg::ErrNone;
    if (cmd_i.push_opd || cmd_i.push_res) begin
      if (sp_full) begin
        raise      = 1'b1;
        raise_code = pesev_pkg::ErrOver;
      end else begin
        we   = 1'b1;
        sp_d = sp_q + 1'b1;
      end
    end
    if (cmd_i.pop_a || cmd_i.pop_b || cmd_i.top_rd) begin
      rd_hit_d = !sp_empty;
      if (sp_empty) begin
        raise      = 1'b1;
        raise_code = pesev_pkg::ErrUnder;
      end else begin
        re = 1'b1;
        if (!cmd_i.top_rd) begin
          sp_d = sp_m1;
        end
      end
    end
    if (cmd_i.exec && (tok_op_q == pesev_pkg::OpAdd || tok_op_q == pesev_pkg::OpSub)
        && sum_ovf) begin
      raise      = 1'b1;
      raise_code = pesev_pkg::ErrSat;
    end
    if (cmd_i.mul_fin && !mul_fits) begin
      raise      = 1'b1;
      raise_code = pesev_pkg::ErrSat;
    end
    if (cmd_i.div_fin) begin
      if (dz_q) begin
        raise      = 1'b1;
        raise_code = pesev_pkg::ErrDiv0;
      end else if (ovf_q || quo_big) begin
        raise      = 1'b1;
        raise_code = pesev_pkg::ErrSat;
      end
    end
    if (cmd_i.out_load) begin
      sp_d = '0;
    end
  end

  // Keep only the first error of an expression
  always_comb begin
    err_d = err_q;
    if (cmd_i.out_load) begin
      err_d = pesev_pkg::ErrNone;
    end else if (raise && err_q == pesev_pkg::ErrNone) begin
      err_d = raise_code;
    end
  end

  // Operation result
  always_comb begin
    res_d  = res_q;
    prod_d = prod_q;
    if (cmd_i.exec) begin
      if (tok_op_q == pesev_pkg::OpMul) begin
        prod_d = a_q * b_q;
      end else if (sum_ovf) begin
        res_d = sum[DW] ? pesev_pkg::QMin : pesev_pkg::QMax;
      end else begin
        res_d = sum[DW-1:0];
      end
    end
    if (cmd_i.mul_fin) begin
      if (mul_fits) begin
        res_d = prod_q[DW+FW-1:FW];
      end else begin
        res_d = prod_q[2*DW-1] ? pesev_pkg::QMin : pesev_pkg::QMax;
      end
    end
    if (cmd_i.div_fin) begin
      if (dz_q) begin
        res_d = asign_q ? pesev_pkg::QMin : pesev_pkg::QMax;
      end else if (ovf_q || quo_big) begin
        res_d = neg_q ? pesev_pkg::QMin : pesev_pkg::QMax;
      end else begin
        res_d = neg_q ? (~quo + 1'b1) : quo;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      err_q       <= pesev_pkg::ErrNone;
      rd_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sp_q     <= sp_d;
      err_q    <= err_d;
      rd_hit_q <= rd_hit_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tok) begin
      tok_op_q   <= op_i;
      tok_opd_q  <= operand_i;
      tok_last_q <= last_i;
    end
    if (cmd_i.cap_a) begin
      a_q <= rd_hit_q ? rdata : '0;
    end
    if (cmd_i.cap_b) begin
      b_q <= rd_hit_q ? rdata : '0;
    end
    if (div_start) begin
      dz_q    <= (b_q == '0);
      ovf_q   <= div_pre_ovf;
      neg_q   <= a_q[DW-1] ^ b_q[DW-1];
      asign_q <= a_q[DW-1];
    end
    res_q  <= res_d;
    prod_q <= prod_d;
    if (cmd_i.out_load) begin
      out_res_q <= rd_hit_q ? rdata : '0;
      out_err_q <= err_q;
    end
  end

  assign status_o.op       = tok_op_q;
  assign status_o.last     = tok_last_q;
  assign status_o.div_done = div_done;
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign result_o    = out_res_q;
  assign error_o     = out_err_q;

endmodule

@@ hdl/pesev_ctrl.sv @@
`timescale 1ns / 1ps

module pesev_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pesev_pkg::status_t status_i,
  output pesev_pkg::cmd_t    cmd_o
);

  pesev_pkg::state_e state_q, state_d;
  logic              is_arith;
  pesev_pkg::state_e after_tok;

  assign is_arith  = (status_i.op == pesev_pkg::OpAdd) || (status_i.op == pesev_pkg::OpSub)
                  || (status_i.op == pesev_pkg::OpMul) || (status_i.op == pesev_pkg::OpDiv);
  assign after_tok = status_i.last ? pesev_pkg::StTopRd : pesev_pkg::StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pesev_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one token at a time
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pesev_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_tok = 1'b1;
          state_d        = pesev_pkg::StDispatch;
        end
      end
      pesev_pkg::StDispatch: begin
        if (status_i.op == pesev_pkg::OpPush) begin
          cmd_o.push_opd = 1'b1;
          state_d        = after_tok;
        end else if (is_arith) begin
          state_d = pesev_pkg::StPopA;
        end else begin
          state_d = after_tok;
        end
      end
      pesev_pkg::StPopA: begin
        cmd_o.pop_a = 1'b1;
        state_d     = pesev_pkg::StPopB;
      end
      pesev_pkg::StPopB: begin
        cmd_o.cap_a = 1'b1;
        cmd_o.pop_b = 1'b1;
        state_d     = pesev_pkg::StCapB;
      end
      pesev_pkg::StCapB: begin
        cmd_o.cap_b = 1'b1;
        state_d     = pesev_pkg::StExec;
      end
      pesev_pkg::StExec: begin
        cmd_o.exec = 1'b1;
        if (status_i.op == pesev_pkg::OpMul) begin
          state_d = pesev_pkg::StMulFin;
        end else if (status_i.op == pesev_pkg::OpDiv) begin
          state_d = pesev_pkg::StDivRun;
        end else begin
          state_d = pesev_pkg::StPushRes;
        end
      end
      pesev_pkg::StMulFin: begin
        cmd_o.mul_fin = 1'b1;
        state_d       = pesev_pkg::StPushRes;
      end
      pesev_pkg::StDivRun: begin
        if (status_i.div_done) begin
          cmd_o.div_fin = 1'b1;
          state_d       = pesev_pkg::StPushRes;
        end
      end
      pesev_pkg::StPushRes: begin
        cmd_o.push_res = 1'b1;
        state_d        = after_tok;
      end
      pesev_pkg::StTopRd: begin
        cmd_o.top_rd = 1'b1;
        state_d      = pesev_pkg::StTopWait;
      end
      pesev_pkg::StTopWait: begin
        // Hold until the output register can take the beat
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = pesev_pkg::StIdle;
        end
      end
      default: begin
        state_d = pesev_pkg::StIdle;
      end
    endcase
  end

endmodule

@@ hdl/prefix_expression_stack_evaluator_core.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Beat
// in       input      in_valid_i/in_ready_o  op_i, operand_i, last_i
// out      output     out_valid_o/out_ready_i result_o, error_o
//
// Divides run on the one-bit-per-cycle restoring divider (32 steps). A last token
// adds a top-of-stack read and a wait until the output register is free.
// Reset empties the stack and clears the error; stack memory itself is not cleared.
// A result beat waits in the output register; the next token is still accepted,
// and only a following last token stalls until that beat is taken.
module prefix_expression_stack_evaluator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [pesev_pkg::OpW-1:0]          op_i,
  input  logic signed [pesev_pkg::DataW-1:0] operand_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [pesev_pkg::DataW-1:0] result_o,
  output logic [pesev_pkg::ErrW-1:0]         error_o
);

  pesev_pkg::cmd_t    cmd;
  pesev_pkg::status_t status;

  pesev_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pesev_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .op_i        (op_i),
    .operand_i   (operand_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o),
    .error_o     (error_o)
  );

endmodule

@@ hdl/pesev_chk.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pesev_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [pesev_pkg::OpW-1:0]          op_i,
  input logic signed [pesev_pkg::DataW-1:0] operand_i,
  input logic                               last_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [pesev_pkg::DataW-1:0] result_o,
  input logic [pesev_pkg::ErrW-1:0]         error_o
);

  // A stalled result beat holds
  `PESEV_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o) && $stable(error_o))

  // No result while in reset
  `PESEV_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o)

  // One token at a time: ready drops after each accepted beat
  `PESEV_ASSERT(a_one_tok, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // Reported error codes stay within the defined set
  `PESEV_ASSERT(a_err_code, clk_i, rst_ni, out_valid_o |-> error_o <= pesev_pkg::ErrSat)

endmodule

bind prefix_expression_stack_evaluator_core pesev_chk u_pesev_chk (.*);
